@@ rtl/tsmf_pkg.sv @@
package tsmf_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int OUTCOME_BITS = 2;

  localparam logic [SAMPLE_BITS-1:0] SPREAD_LIMIT_RESET = SAMPLE_BITS'(5);

  localparam logic [OUTCOME_BITS-1:0] OUTCOME_NEW_AVG  = 2'd0;
  localparam logic [OUTCOME_BITS-1:0] OUTCOME_HELD     = 2'd1;
  localparam logic [OUTCOME_BITS-1:0] OUTCOME_NO_TOUCH = 2'd2;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample_a;
    sample_t sample_b;
    sample_t sample_c;
    sample_t sample_d;
    logic    channel_is_y;
    logic    pen_down;
  } in_item_t;

  typedef struct packed {
    sample_t                 filtered_value;
    logic [OUTCOME_BITS-1:0] outcome;
  } out_item_t;

endpackage

@@ rtl/touch_sample_median_filter_core.sv @@
// channel | direction | handshake              | payload
// --------+-----------+------------------------+-------------------------------
// in_     | input     | in_valid / in_stall    | in_item  (four samples, flags)
// out_    | output    | out_valid / out_stall  | out_item (value, outcome)
// cfg_    | input     | cfg_valid / cfg_ready  | cfg_data (spread limit)
//
// one item per cycle while out_stall is low: a transfer lands in the input
// register, the sorting network, gap compare and average sit between it and
// the result register, which drives out_valid and out_item
// the held slots update in the cycle the item moves into the result register
// reset (synchronous, rst_n low) empties both registers, clears the held
// slots and sets the spread limit to 5
// a stall on the result side holds the result register and then the input
// register; only when both are full and stalled is in_stall raised
module touch_sample_median_filter_core
  import tsmf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,

  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,

  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,

  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  sample_t   cfg_data
);

  // input register
  logic     in_v_r;
  in_item_t in_r;

  // result register
  logic      out_v_r;
  out_item_t out_r;

  // filter state
  sample_t spread_limit_r;
  sample_t held_y_r;
  sample_t held_other_r;

  logic in_take;
  logic advance;

  // sorting network and decision
  sample_t   p0, p1, p2, p3;
  sample_t   q1, q2;
  sample_t   mid_lo, mid_hi;
  sample_t   gap;
  logic [SAMPLE_BITS:0] mid_sum;
  sample_t   avg;
  logic      reject;
  sample_t   held_sel;
  out_item_t res_nxt;
  logic      store_y;
  logic      store_other;

  // result register moves when empty or its transfer completes
  assign advance  = !out_v_r || !out_stall;
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  always_comb begin
    // first layer: (a,b) and (c,d)
    p0 = (in_r.sample_a > in_r.sample_b) ? in_r.sample_b : in_r.sample_a;
    p1 = (in_r.sample_a > in_r.sample_b) ? in_r.sample_a : in_r.sample_b;
    p2 = (in_r.sample_c > in_r.sample_d) ? in_r.sample_d : in_r.sample_c;
    p3 = (in_r.sample_c > in_r.sample_d) ? in_r.sample_c : in_r.sample_d;
    // second layer: only the larger low and the smaller high feed the middle
    q2 = (p0 > p2) ? p0 : p2;
    q1 = (p1 > p3) ? p3 : p1;
    // last exchange settles the middle pair; extremes are not needed
    mid_lo = (q1 > q2) ? q2 : q1;
    mid_hi = (q1 > q2) ? q1 : q2;

    gap      = mid_hi - mid_lo;
    reject   = gap > spread_limit_r;
    mid_sum  = {1'b0, mid_lo} + {1'b0, mid_hi};
    avg      = mid_sum[SAMPLE_BITS:1];
    held_sel = in_r.channel_is_y ? held_y_r : held_other_r;

    if (!in_r.pen_down) begin
      res_nxt.filtered_value = '0;
      res_nxt.outcome        = OUTCOME_NO_TOUCH;
    end else if (reject) begin
      res_nxt.filtered_value = held_sel;
      res_nxt.outcome        = OUTCOME_HELD;
    end else begin
      res_nxt.filtered_value = avg;
      res_nxt.outcome        = OUTCOME_NEW_AVG;
    end

    store_y     = in_v_r && advance && in_r.pen_down && !reject && in_r.channel_is_y;
    store_other = in_v_r && advance && in_r.pen_down && !reject && !in_r.channel_is_y;
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      spread_limit_r <= SPREAD_LIMIT_RESET;
      held_y_r       <= '0;
      held_other_r   <= '0;
    end else begin
      if (advance) begin
        out_v_r <= in_v_r;
      end
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (cfg_valid && cfg_ready) begin
        spread_limit_r <= cfg_data;
      end
      if (store_y) begin
        held_y_r <= avg;
      end
      if (store_other) begin
        held_other_r <= avg;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_item;
    end
    if (advance && in_v_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  // input side only backs up when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && out_v_r && out_stall))
    else $error("in_stall raised without a stalled result");

  // no-touch results always carry a zero value
  a_no_touch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.outcome == OUTCOME_NO_TOUCH) |-> (out_item.filtered_value == '0))
    else $error("no-touch result with nonzero value");

  // a fresh average for the y channel is what the y slot holds afterwards
  a_y_store: assert property (@(posedge clk) disable iff (!rst_n)
    store_y |=> (held_y_r == out_item.filtered_value && out_item.outcome == OUTCOME_NEW_AVG))
    else $error("y slot does not match the new average");

  // outcome code three never appears
  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.outcome == OUTCOME_NEW_AVG || out_item.outcome == OUTCOME_HELD ||
                   out_item.outcome == OUTCOME_NO_TOUCH))
    else $error("bad outcome code");
`endif

endmodule
